>>> hw/rtl/pra_pkg.sv
package pra_pkg;

	// request kinds
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_CLAIM = 2'd2;

	// configuration register indexes
	localparam logic CFG_BASE  = 1'b0;
	localparam logic CFG_PAGES = 1'b1;

	// page numbers and counts
	localparam int PAGE_W = 52;

	// undo journal
	localparam int JDEPTH = 8;
	localparam int JW     = 3;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOFIT   = 3'd1,
		ST_BAD     = 3'd2,
		ST_OVERLAP = 3'd3,
		ST_POOL    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_ONE,
		PH_LEAD,
		PH_TAIL
	} phase_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_FIT_READ,
		S_FIT_EXAM,
		S_FIT_DROP,
		S_ALIGN,
		S_SPLIT,
		S_INS_READ,
		S_INS_EXAM,
		S_INS_MERGE,
		S_INS_DROP,
		S_TAKE,
		S_TAKE_LINK,
		S_FC_READ,
		S_FC_EXAM,
		S_FC_DROP,
		S_SPLIT_CUR,
		S_OP_DONE,
		S_ROLLBACK,
		S_DONE
	} state_t;

endpackage

>>> hw/rtl/page_range_allocator_core.sv
// Channel  | handshake             | payload
// ---------+-----------------------+-----------------------------------------------
// request  | in_valid / in_ready   | req_type, address, byte_len, align_size
// result   | out_valid / out_ready | result_address, status
// config   | cfg_we                | cfg_addr (0 region_base, 1 region_pages), cfg_wdata
//
// One request word at a time. A request walks the lists node by node, may run
// free-node scans (lowest free index, one node memory read per cycle), and on
// failure undoes its journal entries.
// An aligned allocate walks the hole list up to three times (fit, lead, tail).
// After reset and after every region_pages write the node memory is swept, one
// entry per cycle; in_ready stays low meanwhile.
// The result sits in an output register: a stalled result holds only the next
// request's final cycle, the request side is free as soon as the result is latched.
module page_range_allocator_core #(
	parameter int NODE_COUNT = 64,
	parameter int PAGE_BITS  = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [63:0] cfg_wdata,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [63:0] address,
	input  logic [43:0] byte_len,
	input  logic [31:0] align_size,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_address,
	output logic [2:0]  status
);

	localparam int PW = pra_pkg::PAGE_W;
	localparam int AW = $clog2(NODE_COUNT);
	localparam int LW = $clog2(NODE_COUNT + 1);
	localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);
	localparam logic [AW-1:0] LAST_IDX = AW'(NODE_COUNT - 1);
	localparam logic [31:0] PAGE_BYTES32 = 32'(64'd1 << PAGE_BITS);
	localparam logic [63:0] SIZE_LIMIT = 64'(64'hffffffff << PAGE_BITS);
	localparam logic [44:0] PG_RND = 45'((64'd1 << PAGE_BITS) - 64'd1);
	localparam int JW = pra_pkg::JW;

	typedef struct packed {
		logic [PW-1:0] start;
		logic [PW-1:0] count;
		logic [LW-1:0] link;
		logic          used;
	} node_t;

	// ---------------------------------------------------------------- registers
	pra_pkg::state_t  state_q, state_d;
	pra_pkg::status_t st_q, st_d;
	pra_pkg::phase_t  ph_q, ph_d;

	logic [63:0]   region_base_q;
	logic [PW-1:0] region_pages_q;
	logic [LW-1:0] hole_head_q, hole_head_d, claim_head_q, claim_head_d;
	logic [LW-1:0] hh_sv_q, hh_sv_d, ch_sv_q, ch_sv_d;
	logic [AW-1:0] clr_q, clr_d;
	logic [JW-1:0] jcnt_q, jcnt_d;

	// request word
	logic [1:0]  type_q;
	logic [63:0] addr_q;
	logic [43:0] nb_q;
	logic [31:0] al_q;

	// walk and arithmetic registers
	logic [LW-1:0] cur_q, cur_d, prev_q, prev_d, scan_q, scan_d;
	logic [AW-1:0] n_q, n_d;
	logic          chk_q, chk_d, split_q, split_d, csel_q, csel_d;
	node_t         prevd_q, prevd_d, curd_q, curd_d, nxd_q, nxd_d;
	logic [PW-1:0] base_q, base_d, len_q, len_d;
	logic [PW-1:0] need_q, need_d, pg_q, pg_d, ap_q, ap_d;
	logic [PW-1:0] b_q, b_d, a_q, a_d, tail_q, tail_d;
	logic [63:0]   res_q, res_d;

	// output register
	logic          out_valid_q;
	logic [63:0]   out_addr_q;
	logic [2:0]    out_st_q;
	logic          out_load;

	// node memory and journal
	node_t         node_mem [NODE_COUNT];
	node_t         rd_q;
	logic [AW-1:0] ridx_q, raddr;
	logic          wr_en, wr_log;
	logic [AW-1:0] wr_idx;
	node_t         wr_new, wr_old;
	logic [AW-1:0] jidx_q [pra_pkg::JDEPTH];
	node_t         jold_q [pra_pkg::JDEPTH];

	logic accept;

	// ---------------------------------------------------------------- datapath
	logic [PW:0]   se_w, end_w, cse_w;
	logic          ovl_w;
	logic [44:0]   nb_sum;
	logic [PW-1:0] pages_w, ap_w, need_w, a_w, cbase_w;
	logic [63:0]   off_w, rp64, res_alloc;
	logic          al_ok, size_ok, hole_ok, claim_ok;

	assign se_w  = {1'b0, rd_q.start} + {1'b0, rd_q.count};
	assign end_w = {1'b0, base_q} + {1'b0, len_q};
	assign cse_w = {1'b0, curd_q.start} + {1'b0, curd_q.count};
	// new range collides with the node just read
	assign ovl_w = (rd_q.start < base_q) ? (se_w > {1'b0, base_q})
		: (end_w > {1'b0, rd_q.start});

	assign nb_sum  = {1'b0, nb_q} + PG_RND;
	assign pages_w = PW'(nb_sum >> PAGE_BITS);
	assign ap_w    = PW'(al_q >> PAGE_BITS);
	assign need_w  = pages_w + ap_w - PW'(1);
	assign al_ok   = (al_q >= PAGE_BYTES32) && ((al_q & (al_q - 32'd1)) == 32'd0);
	assign size_ok = (nb_q != 44'd0) && (64'(nb_q) <= SIZE_LIMIT);
	assign off_w   = (addr_q - region_base_q) >> PAGE_BITS;
	assign rp64    = 64'(region_pages_q);
	assign hole_ok = (off_w <= rp64) && (64'(pages_w) <= rp64 - off_w);
	assign claim_ok = (addr_q <= region_base_q) && (64'(nb_q) <= region_base_q - addr_q)
		&& (addr_q[PAGE_BITS-1:0] == '0) && (nb_q != 44'd0);
	assign cbase_w = PW'(addr_q >> PAGE_BITS);
	// round the fit base up to the alignment
	assign a_w = (b_q + ap_q - PW'(1)) & ~(ap_q - PW'(1));
	assign res_alloc = (64'(a_q) << PAGE_BITS) + region_base_q;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == pra_pkg::S_IDLE);
	assign out_load = (state_q == pra_pkg::S_DONE) && (!out_valid_q || out_ready);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pra_pkg::S_CLEAR;
			clr_q <= '0;
			hole_head_q <= '0;
			claim_head_q <= NIL;
			jcnt_q <= '0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			hole_head_q <= hole_head_d;
			claim_head_q <= claim_head_d;
			jcnt_q <= jcnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		st_d = st_q;
		ph_d = ph_q;
		hole_head_d = hole_head_q;
		claim_head_d = claim_head_q;
		hh_sv_d = hh_sv_q;
		ch_sv_d = ch_sv_q;
		clr_d = clr_q;
		jcnt_d = jcnt_q;
		cur_d = cur_q;
		prev_d = prev_q;
		scan_d = scan_q;
		n_d = n_q;
		chk_d = chk_q;
		split_d = split_q;
		csel_d = csel_q;
		prevd_d = prevd_q;
		curd_d = curd_q;
		nxd_d = nxd_q;
		base_d = base_q;
		len_d = len_q;
		need_d = need_q;
		pg_d = pg_q;
		ap_d = ap_q;
		b_d = b_q;
		a_d = a_q;
		tail_d = tail_q;
		res_d = res_q;
		raddr = cur_q[AW-1:0];
		wr_en = 1'b0;
		wr_log = 1'b0;
		wr_idx = cur_q[AW-1:0];
		wr_new = rd_q;
		wr_old = rd_q;

		case (state_q)
			pra_pkg::S_CLEAR: begin
				wr_en = 1'b1;
				wr_idx = clr_q;
				wr_new.start = '0;
				wr_new.count = (clr_q == '0) ? region_pages_q : '0;
				wr_new.link = NIL;
				wr_new.used = (clr_q == '0);
				if (clr_q == LAST_IDX) begin
					state_d = pra_pkg::S_IDLE;
				end else begin
					clr_d = clr_q + AW'(1);
				end
			end
			pra_pkg::S_IDLE: begin
				if (accept) begin
					hh_sv_d = hole_head_q;
					ch_sv_d = claim_head_q;
					jcnt_d = '0;
					state_d = pra_pkg::S_DECODE;
				end
			end
			pra_pkg::S_DECODE: begin
				st_d = pra_pkg::ST_BAD;
				res_d = '1;
				ph_d = pra_pkg::PH_ONE;
				prev_d = NIL;
				pg_d = pages_w;
				len_d = pages_w;
				state_d = pra_pkg::S_DONE;
				case (type_q)
					pra_pkg::REQ_ALLOC: begin
						if (al_ok && size_ok) begin
							ap_d = ap_w;
							need_d = need_w;
							cur_d = hole_head_q;
							state_d = pra_pkg::S_FIT_READ;
						end
					end
					pra_pkg::REQ_FREE: begin
						res_d = '0;
						if (nb_q != 44'd0) begin
							if (addr_q >= region_base_q) begin
								if (hole_ok) begin
									base_d = off_w[PW-1:0];
									csel_d = 1'b0;
									cur_d = hole_head_q;
									state_d = pra_pkg::S_INS_READ;
								end
							end else begin
								base_d = cbase_w;
								cur_d = claim_head_q;
								state_d = pra_pkg::S_FC_READ;
							end
						end
					end
					pra_pkg::REQ_CLAIM: begin
						if (claim_ok) begin
							base_d = cbase_w;
							csel_d = 1'b1;
							cur_d = claim_head_q;
							state_d = pra_pkg::S_INS_READ;
						end
					end
					default: begin
						state_d = pra_pkg::S_DONE;
					end
				endcase
			end

			// first-fit walk over the hole list
			pra_pkg::S_FIT_READ: begin
				if (cur_q == NIL) begin
					st_d = pra_pkg::ST_NOFIT;
					state_d = pra_pkg::S_ROLLBACK;
				end else begin
					state_d = pra_pkg::S_FIT_EXAM;
				end
			end
			pra_pkg::S_FIT_EXAM: begin
				if (rd_q.count >= need_q) begin
					b_d = rd_q.start;
					curd_d = rd_q;
					if (rd_q.count == need_q) begin
						if (prev_q != NIL) begin
							wr_en = 1'b1;
							wr_log = 1'b1;
							wr_idx = prev_q[AW-1:0];
							wr_old = prevd_q;
							wr_new = prevd_q;
							wr_new.link = rd_q.link;
						end else begin
							hole_head_d = rd_q.link;
						end
						state_d = pra_pkg::S_FIT_DROP;
					end else begin
						wr_en = 1'b1;
						wr_log = 1'b1;
						wr_new.start = rd_q.start + need_q;
						wr_new.count = rd_q.count - need_q;
						state_d = pra_pkg::S_ALIGN;
					end
				end else begin
					prev_d = cur_q;
					prevd_d = rd_q;
					cur_d = rd_q.link;
					state_d = pra_pkg::S_FIT_READ;
				end
			end
			pra_pkg::S_FIT_DROP: begin
				wr_en = 1'b1;
				wr_log = 1'b1;
				wr_old = curd_q;
				wr_new = curd_q;
				wr_new.used = 1'b0;
				state_d = pra_pkg::S_ALIGN;
			end
			pra_pkg::S_ALIGN: begin
				a_d = a_w;
				state_d = pra_pkg::S_SPLIT;
			end
			pra_pkg::S_SPLIT: begin
				// tail = (b + need) - (a + pages)
				tail_d = (b_q + need_q) - (a_q + pg_q);
				csel_d = 1'b0;
				cur_d = hole_head_q;
				prev_d = NIL;
				if (a_q != b_q) begin
					base_d = b_q;
					len_d = a_q - b_q;
					ph_d = pra_pkg::PH_LEAD;
					state_d = pra_pkg::S_INS_READ;
				end else begin
					ph_d = pra_pkg::PH_LEAD;
					state_d = pra_pkg::S_OP_DONE;
				end
			end

			// sorted insert with coalescing
			pra_pkg::S_INS_READ: begin
				if (cur_q == NIL) begin
					scan_d = '0;
					chk_d = 1'b0;
					split_d = 1'b0;
					state_d = pra_pkg::S_TAKE;
				end else begin
					state_d = pra_pkg::S_INS_EXAM;
				end
			end
			pra_pkg::S_INS_EXAM: begin
				curd_d = rd_q;
				if (ovl_w) begin
					st_d = pra_pkg::ST_OVERLAP;
					state_d = pra_pkg::S_ROLLBACK;
				end else if (end_w == {1'b0, rd_q.start}) begin
					wr_en = 1'b1;
					wr_log = 1'b1;
					wr_new.start = base_q;
					wr_new.count = rd_q.count + len_q;
					state_d = pra_pkg::S_OP_DONE;
				end else if (se_w == {1'b0, base_q}) begin
					if (rd_q.link != NIL) begin
						raddr = rd_q.link[AW-1:0];
						state_d = pra_pkg::S_INS_MERGE;
					end else begin
						wr_en = 1'b1;
						wr_log = 1'b1;
						wr_new.count = rd_q.count + len_q;
						state_d = pra_pkg::S_OP_DONE;
					end
				end else if ({1'b0, rd_q.start} > end_w) begin
					scan_d = '0;
					chk_d = 1'b0;
					split_d = 1'b0;
					state_d = pra_pkg::S_TAKE;
				end else begin
					prev_d = cur_q;
					prevd_d = rd_q;
					cur_d = rd_q.link;
					state_d = pra_pkg::S_INS_READ;
				end
			end
			pra_pkg::S_INS_MERGE: begin
				// rd_q holds the successor of the node that ends at the new base
				wr_en = 1'b1;
				wr_log = 1'b1;
				wr_old = curd_q;
				wr_new = curd_q;
				nxd_d = rd_q;
				if ({1'b0, rd_q.start} == end_w) begin
					wr_new.count = curd_q.count + len_q + rd_q.count;
					wr_new.link = rd_q.link;
					state_d = pra_pkg::S_INS_DROP;
				end else begin
					wr_new.count = curd_q.count + len_q;
					state_d = pra_pkg::S_OP_DONE;
				end
			end
			pra_pkg::S_INS_DROP: begin
				wr_en = 1'b1;
				wr_log = 1'b1;
				wr_idx = curd_q.link[AW-1:0];
				wr_old = nxd_q;
				wr_new = nxd_q;
				wr_new.used = 1'b0;
				state_d = pra_pkg::S_OP_DONE;
			end

			// lowest free node: one read issued per cycle, checked the next
			pra_pkg::S_TAKE: begin
				if (chk_q && !rd_q.used) begin
					n_d = ridx_q;
					wr_en = 1'b1;
					wr_log = 1'b1;
					wr_idx = ridx_q;
					wr_new.used = 1'b1;
					if (split_q) begin
						wr_new.start = end_w[PW-1:0];
						wr_new.count = PW'(cse_w - end_w);
						wr_new.link = curd_q.link;
						state_d = pra_pkg::S_SPLIT_CUR;
					end else begin
						wr_new.start = base_q;
						wr_new.count = len_q;
						wr_new.link = cur_q;
						state_d = pra_pkg::S_TAKE_LINK;
					end
				end else if (scan_q == NIL) begin
					st_d = pra_pkg::ST_POOL;
					state_d = pra_pkg::S_ROLLBACK;
				end else begin
					raddr = scan_q[AW-1:0];
					scan_d = scan_q + LW'(1);
					chk_d = 1'b1;
				end
			end
			pra_pkg::S_TAKE_LINK: begin
				if (prev_q != NIL) begin
					wr_en = 1'b1;
					wr_log = 1'b1;
					wr_idx = prev_q[AW-1:0];
					wr_old = prevd_q;
					wr_new = prevd_q;
					wr_new.link = LW'(n_q);
				end else if (csel_q) begin
					claim_head_d = LW'(n_q);
				end else begin
					hole_head_d = LW'(n_q);
				end
				state_d = pra_pkg::S_OP_DONE;
			end

			// cut a range out of the claims list
			pra_pkg::S_FC_READ: begin
				if (cur_q == NIL) begin
					st_d = pra_pkg::ST_OVERLAP;
					state_d = pra_pkg::S_ROLLBACK;
				end else begin
					state_d = pra_pkg::S_FC_EXAM;
				end
			end
			pra_pkg::S_FC_EXAM: begin
				curd_d = rd_q;
				if ((rd_q.start <= base_q) && (se_w >= end_w)) begin
					if (rd_q.start == base_q) begin
						if (rd_q.count == len_q) begin
							if (prev_q != NIL) begin
								wr_en = 1'b1;
								wr_log = 1'b1;
								wr_idx = prev_q[AW-1:0];
								wr_old = prevd_q;
								wr_new = prevd_q;
								wr_new.link = rd_q.link;
							end else begin
								claim_head_d = rd_q.link;
							end
							state_d = pra_pkg::S_FC_DROP;
						end else begin
							wr_en = 1'b1;
							wr_log = 1'b1;
							wr_new.start = rd_q.start + len_q;
							wr_new.count = rd_q.count - len_q;
							state_d = pra_pkg::S_OP_DONE;
						end
					end else if (se_w == end_w) begin
						wr_en = 1'b1;
						wr_log = 1'b1;
						wr_new.count = rd_q.count - len_q;
						state_d = pra_pkg::S_OP_DONE;
					end else begin
						// middle cut: a new node takes the upper piece
						scan_d = '0;
						chk_d = 1'b0;
						split_d = 1'b1;
						state_d = pra_pkg::S_TAKE;
					end
				end else if (({1'b0, rd_q.start} > end_w) || ovl_w) begin
					st_d = pra_pkg::ST_OVERLAP;
					state_d = pra_pkg::S_ROLLBACK;
				end else begin
					prev_d = cur_q;
					prevd_d = rd_q;
					cur_d = rd_q.link;
					state_d = pra_pkg::S_FC_READ;
				end
			end
			pra_pkg::S_FC_DROP: begin
				wr_en = 1'b1;
				wr_log = 1'b1;
				wr_old = curd_q;
				wr_new = curd_q;
				wr_new.used = 1'b0;
				state_d = pra_pkg::S_OP_DONE;
			end
			pra_pkg::S_SPLIT_CUR: begin
				wr_en = 1'b1;
				wr_log = 1'b1;
				wr_old = curd_q;
				wr_new = curd_q;
				wr_new.count = base_q - curd_q.start;
				wr_new.link = LW'(n_q);
				state_d = pra_pkg::S_OP_DONE;
			end

			pra_pkg::S_OP_DONE: begin
				if ((ph_q == pra_pkg::PH_LEAD) && (tail_q != '0)) begin
					base_d = a_q + pg_q;
					len_d = tail_q;
					csel_d = 1'b0;
					cur_d = hole_head_q;
					prev_d = NIL;
					ph_d = pra_pkg::PH_TAIL;
					state_d = pra_pkg::S_INS_READ;
				end else begin
					st_d = pra_pkg::ST_OK;
					case (type_q)
						pra_pkg::REQ_ALLOC: res_d = res_alloc;
						pra_pkg::REQ_CLAIM: res_d = addr_q;
						default: res_d = '0;
					endcase
					state_d = pra_pkg::S_DONE;
				end
			end

			// failure: undo node writes newest first, then the list heads
			pra_pkg::S_ROLLBACK: begin
				res_d = (type_q == pra_pkg::REQ_FREE) ? '0 : '1;
				if (jcnt_q == '0) begin
					hole_head_d = hh_sv_q;
					claim_head_d = ch_sv_q;
					state_d = pra_pkg::S_DONE;
				end else begin
					wr_en = 1'b1;
					wr_idx = jidx_q[jcnt_q - JW'(1)];
					wr_new = jold_q[jcnt_q - JW'(1)];
					jcnt_d = jcnt_q - JW'(1);
				end
			end
			pra_pkg::S_DONE: begin
				if (out_load) begin
					state_d = pra_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pra_pkg::S_IDLE;
			end
		endcase

		if (wr_log) begin
			jcnt_d = jcnt_q + JW'(1);
		end

		// region_pages write empties the claims list, resets the hole list to one node and sweeps the pool
		if (cfg_we && (cfg_addr == pra_pkg::CFG_PAGES)) begin
			state_d = pra_pkg::S_CLEAR;
			clr_d = '0;
			hole_head_d = '0;
			claim_head_d = NIL;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		st_q <= st_d;
		ph_q <= ph_d;
		hh_sv_q <= hh_sv_d;
		ch_sv_q <= ch_sv_d;
		cur_q <= cur_d;
		prev_q <= prev_d;
		scan_q <= scan_d;
		n_q <= n_d;
		chk_q <= chk_d;
		split_q <= split_d;
		csel_q <= csel_d;
		prevd_q <= prevd_d;
		curd_q <= curd_d;
		nxd_q <= nxd_d;
		base_q <= base_d;
		len_q <= len_d;
		need_q <= need_d;
		pg_q <= pg_d;
		ap_q <= ap_d;
		b_q <= b_d;
		a_q <= a_d;
		tail_q <= tail_d;
		res_q <= res_d;
		if (accept) begin
			type_q <= req_type;
			addr_q <= address;
			nb_q <= byte_len;
			al_q <= align_size;
		end
		if (out_load) begin
			out_addr_q <= res_q;
			out_st_q <= st_q;
		end
	end

	// configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= '0;
			region_pages_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_addr == pra_pkg::CFG_BASE)) begin
				region_base_q <= cfg_wdata;
			end
			if (cfg_we && (cfg_addr == pra_pkg::CFG_PAGES)) begin
				region_pages_q <= cfg_wdata[PW-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// node memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem[wr_idx] <= wr_new;
		end
		rd_q <= node_mem[raddr];
		ridx_q <= raddr;
	end

	// undo journal
	always_ff @(posedge clk) begin
		if (wr_log) begin
			jidx_q[jcnt_q] <= wr_idx;
			jold_q[jcnt_q] <= wr_old;
		end
	end

	assign out_valid = out_valid_q;
	assign result_address = out_addr_q;
	assign status = out_st_q;

	// ---------------------------------------------------------------- checks
	a_journal_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_log |-> (jcnt_q != JW'(pra_pkg::JDEPTH - 1)))
		else $error("undo journal overflow");

	a_rollback_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pra_pkg::S_ROLLBACK) |-> (st_q != pra_pkg::ST_OK))
		else $error("rollback with ok status");

	a_rollback_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pra_pkg::S_ROLLBACK && state_d == pra_pkg::S_DONE) |-> (jcnt_q == '0))
		else $error("rollback left journal entries");

	a_heads_range: assert property (@(posedge clk) disable iff (!arst_n)
		(hole_head_q <= NIL) && (claim_head_q <= NIL))
		else $error("list head out of range");

endmodule
